### rtl/core/fdp_pkg.sv
// Shared types and constants for the framed decimal parser.
`default_nettype none

package fdp_pkg;

  localparam int MAX_DIGITS_DEFAULT = 4;
  localparam int CMD_DEPTH_DEFAULT  = 2;

  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int VALUE_W = 14;

  localparam logic [BYTE_W-1:0]  CH_OPEN   = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0]  CH_CLOSE  = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0]  CH_ZERO   = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0]  CH_NINE   = 8'h39;  // '9'
  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

  typedef enum logic [1:0] {
    KIND_OPEN,
    KIND_CLOSE,
    KIND_DIGIT,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/fdp_front.sv
// Front end: classifies each received byte into a parser command.
`default_nettype none

module fdp_front (
  input  wire logic [fdp_pkg::BYTE_W-1:0] rx_byte,
  output fdp_pkg::cmd_t                   cmd
);

  logic [fdp_pkg::BYTE_W-1:0] offset;

  assign offset = rx_byte - fdp_pkg::CH_ZERO;

  always_comb begin
    cmd.digit = offset[fdp_pkg::DIGIT_W-1:0];
    if (rx_byte == fdp_pkg::CH_OPEN) begin
      cmd.kind = fdp_pkg::KIND_OPEN;
    end else if (rx_byte == fdp_pkg::CH_CLOSE) begin
      cmd.kind = fdp_pkg::KIND_CLOSE;
    end else if (rx_byte >= fdp_pkg::CH_ZERO && rx_byte <= fdp_pkg::CH_NINE) begin
      cmd.kind = fdp_pkg::KIND_DIGIT;
    end else begin
      cmd.kind = fdp_pkg::KIND_OTHER;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fdp_cmd_fifo.sv
// Short command queue between front and back end.
`default_nettype none

module fdp_cmd_fifo #(
  parameter int DEPTH = fdp_pkg::CMD_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fdp_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output fdp_pkg::cmd_t      rd_cmd,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  fdp_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/fdp_back.sv
// Back end: frame state, digit accumulation and the result register.
`default_nettype none

module fdp_back #(
  parameter int MAX_DIGITS = fdp_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fdp_pkg::cmd_t               cmd,
  input  wire logic                        cmd_empty,
  output logic                             cmd_pop,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             value_ready,
  output logic                             new_value,
  output logic [fdp_pkg::VALUE_W-1:0]      value
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
  localparam int PROD_W = fdp_pkg::VALUE_W + 4;

  logic                        in_frame, in_frame_next;
  logic [CNT_W-1:0]            digit_count, digit_count_next;
  logic [fdp_pkg::VALUE_W-1:0] accumulator, accumulator_next;
  logic [fdp_pkg::VALUE_W-1:0] latched_value, latched_value_next;
  logic                        ready_flag, ready_flag_next;
  logic                        pulse;
  logic [PROD_W-1:0]           acc_sum;
  logic                        out_valid;
  logic                        step;

  // Output register refills in the cycle it is drained, if a command is waiting.
  assign cmd_pop = !cmd_empty && (!out_valid || pop);
  assign step    = cmd_pop;
  assign empty   = !out_valid;

  assign acc_sum = PROD_W'(accumulator) * PROD_W'(10) + PROD_W'(cmd.digit);

  always_comb begin
    in_frame_next      = in_frame;
    digit_count_next   = digit_count;
    accumulator_next   = accumulator;
    latched_value_next = latched_value;
    ready_flag_next    = ready_flag;
    pulse              = 1'b0;
    unique case (cmd.kind)
      fdp_pkg::KIND_OPEN: begin
        in_frame_next    = 1'b1;
        ready_flag_next  = 1'b0;
        digit_count_next = '0;
        accumulator_next = '0;
      end
      fdp_pkg::KIND_CLOSE: begin
        if (digit_count != '0) begin
          in_frame_next      = 1'b0;
          latched_value_next = accumulator;
          ready_flag_next    = 1'b1;
          pulse              = 1'b1;
        end
      end
      fdp_pkg::KIND_DIGIT: begin
        if (in_frame) begin
          if (digit_count >= CNT_MAX) begin
            digit_count_next = '0;
            accumulator_next = '0;
            ready_flag_next  = 1'b0;
          end else begin
            // saturate, only reachable with a digit limit above four
            if (acc_sum > PROD_W'(fdp_pkg::VALUE_MAX)) begin
              accumulator_next = fdp_pkg::VALUE_MAX;
            end else begin
              accumulator_next = acc_sum[fdp_pkg::VALUE_W-1:0];
            end
            digit_count_next = digit_count + 1'b1;
          end
        end
      end
      fdp_pkg::KIND_OTHER: begin
        if (in_frame) begin
          digit_count_next = '0;
          in_frame_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      digit_count   <= '0;
      accumulator   <= '0;
      latched_value <= '0;
      ready_flag    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (step) begin
        in_frame      <= in_frame_next;
        digit_count   <= digit_count_next;
        accumulator   <= accumulator_next;
        latched_value <= latched_value_next;
        ready_flag    <= ready_flag_next;
        out_valid     <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      value_ready <= ready_flag_next;
      new_value   <= pulse;
      value       <= latched_value_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/framed_decimal_parser_unit.sv
// Top level of the framed decimal parser: front end, command queue, back end.
//
// Parses received bytes framed as '<' digits '>' (one to MAX_DIGITS digits).
// Input side is a queue: drive rx_byte and raise push; the word is taken at
//   a rising edge with push high and full low.
// Result side is a queue too: while empty is low, value_ready, new_value and
//   value show the oldest result; it is taken at an edge with pop high.
// Every input word yields exactly one result word, in order.
// A taken word sits in the command queue, then loads the back end's result
//   register once that register is empty or being drained by pop.
// Throughput: one word per cycle sustained while pop is held high; the back
//   end's multiply-by-ten-and-add loop sets that figure.
// The front end classifies bytes; a CMD_DEPTH-entry command queue lets the
//   back end stall on its own when pop is held low. Once the queue and the
//   result register are full, full rises and input stops.
// Reset (rst, synchronous, active high) empties both queues, closes any
//   frame, and clears the count, accumulator, latched value and ready flag.
`default_nettype none

module framed_decimal_parser_unit #(
  parameter int MAX_DIGITS = fdp_pkg::MAX_DIGITS_DEFAULT,
  parameter int CMD_DEPTH  = fdp_pkg::CMD_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [fdp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             value_ready,
  output logic                             new_value,
  output logic [fdp_pkg::VALUE_W-1:0]      value
);

  fdp_pkg::cmd_t front_cmd;  // classified input word
  fdp_pkg::cmd_t head_cmd;   // oldest queued command
  logic          cmd_empty;
  logic          cmd_pop;

  fdp_front u_front (
    .rx_byte (rx_byte),
    .cmd     (front_cmd)
  );

  fdp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .full   (full),
    .pop    (cmd_pop),
    .rd_cmd (head_cmd),
    .empty  (cmd_empty)
  );

  fdp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .value_ready (value_ready),
    .new_value   (new_value),
    .value       (value)
  );

endmodule

`default_nettype wire
